### hw/rtl/stlb_pkg.sv
// stlb_pkg: shared constants, word layouts and controller/datapath interface types
// for the sorted table lower-bound search core. No dependencies.
package stlb_pkg;

    localparam int DEPTH     = 1024;
    localparam int KEY_WIDTH = 64;

    localparam int IDX_W = $clog2(DEPTH);   // table index
    localparam int POS_W = IDX_W + 1;       // position / bound, holds DEPTH itself
    localparam int SUM_W = POS_W + 1;       // bound sums

    // input word field widths and offsets (lowest bit first)
    localparam int ENTRY_INDEX_W = 10;
    localparam int ENTRY_VALUE_W = 64;
    localparam int SEARCH_KEY_W  = 64;
    localparam int RANGE_START_W = 10;
    localparam int RANGE_LEN_W   = 11;

    localparam int ENTRY_INDEX_LSB = 0;
    localparam int ENTRY_VALUE_LSB = ENTRY_INDEX_LSB + ENTRY_INDEX_W;
    localparam int SEARCH_KEY_LSB  = ENTRY_VALUE_LSB + ENTRY_VALUE_W;
    localparam int RANGE_START_LSB = SEARCH_KEY_LSB + SEARCH_KEY_W;
    localparam int RANGE_LEN_LSB   = RANGE_START_LSB + RANGE_START_W;
    localparam int S_FIELDS_W      = RANGE_LEN_LSB + RANGE_LEN_W;
    localparam int S_TDATA_W       = ((S_FIELDS_W + 7) / 8) * 8;

    localparam int POSITION_W = 11;
    localparam int M_TDATA_W  = ((POSITION_W + 7) / 8) * 8;

    typedef enum logic {
        REQ_WRITE  = 1'b0,
        REQ_SEARCH = 1'b1
    } req_t;

    // controller -> datapath
    typedef struct packed {
        logic wr_en;     // store one table entry
        logic load;      // capture a search request
        logic step;      // apply one bisection compare
        logic out_load;  // move result into the output register
    } stlb_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic more;      // open bounds still more than one apart
        logic found;     // final check hit
    } stlb_status_t;

endpackage

### hw/rtl/stlb_dp.sv
// stlb_dp: key table memory, search bounds, compare logic and result register.
// Depends on stlb_pkg.
module stlb_dp
    import stlb_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wen,
    input  logic                   cfg_wdata,
    input  logic [S_TDATA_W-1:0]   s_tdata,
    input  stlb_cmd_t              cmd,
    output stlb_status_t           status,
    output logic                   found_out,
    output logic [POSITION_W-1:0]  position_out
);

    logic [KEY_WIDTH-1:0] mem [DEPTH];

    logic                 signed_reg;
    logic [KEY_WIDTH-1:0] key_reg;
    logic [KEY_WIDTH-1:0] rd_data_reg;
    logic [POS_W-1:0]     lo_reg, lo_next;   // lower open bound plus one
    logic [POS_W-1:0]     hi_reg, hi_next;
    logic [POS_W-1:0]     end_reg;
    logic                 found_reg;
    logic [POS_W-1:0]     pos_reg;

    logic [ENTRY_INDEX_W-1:0] entry_index;
    logic [ENTRY_VALUE_W-1:0] entry_value;
    logic [SEARCH_KEY_W-1:0]  search_key;
    logic [RANGE_START_W-1:0] range_start;
    logic [RANGE_LEN_W-1:0]   range_len;

    logic [SUM_W-1:0]     mid_sum;
    logic [IDX_W-1:0]     guess;
    logic [IDX_W-1:0]     rd_addr;
    logic [SUM_W-1:0]     end_sum;
    logic [POS_W-1:0]     end_clip;
    logic [KEY_WIDTH-1:0] rd_ord;
    logic                 less;

    function automatic logic [KEY_WIDTH-1:0] order_of(input logic [KEY_WIDTH-1:0] k,
                                                      input logic s);
        return k ^ {s, {(KEY_WIDTH-1){1'b0}}};
    endfunction

    assign entry_index = s_tdata[ENTRY_INDEX_LSB +: ENTRY_INDEX_W];
    assign entry_value = s_tdata[ENTRY_VALUE_LSB +: ENTRY_VALUE_W];
    assign search_key  = s_tdata[SEARCH_KEY_LSB  +: SEARCH_KEY_W];
    assign range_start = s_tdata[RANGE_START_LSB +: RANGE_START_W];
    assign range_len   = s_tdata[RANGE_LEN_LSB   +: RANGE_LEN_W];

    // probe = floor((high + low) / 2) with low = lo_reg - 1; only used while hi > lo
    assign mid_sum = SUM_W'(hi_reg) + SUM_W'(lo_reg) - SUM_W'(1);
    assign guess   = mid_sum[IDX_W:1];
    assign status.more = (hi_reg > lo_reg);

    // once the bounds meet, keep reading the entry at the final position
    assign rd_addr = status.more ? guess : hi_reg[IDX_W-1:0];

    assign end_sum  = SUM_W'(range_start) + SUM_W'(range_len);
    assign end_clip = (end_sum > SUM_W'(DEPTH)) ? POS_W'(DEPTH) : end_sum[POS_W-1:0];

    assign rd_ord = order_of(rd_data_reg, signed_reg);
    assign less   = (rd_ord < key_reg);
    assign status.found = (hi_reg < end_reg) && (rd_ord == key_reg);

    always_comb begin
        lo_next = lo_reg;
        hi_next = hi_reg;
        if (cmd.load) begin
            lo_next = POS_W'(range_start);
            hi_next = end_clip;
        end else if (cmd.step) begin
            if (less) begin
                lo_next = POS_W'(guess) + POS_W'(1);
            end else begin
                hi_next = POS_W'(guess);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            mem[entry_index[IDX_W-1:0]] <= entry_value[KEY_WIDTH-1:0];
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            signed_reg <= 1'b0;
        end else if (cfg_wen) begin
            signed_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg <= lo_next;
        hi_reg <= hi_next;
        if (cmd.load) begin
            key_reg <= order_of(search_key[KEY_WIDTH-1:0], signed_reg);
            end_reg <= end_clip;
        end
        if (cmd.out_load) begin
            found_reg <= status.found;
            pos_reg   <= hi_reg;
        end
    end

    assign found_out    = found_reg;
    assign position_out = POSITION_W'(pos_reg);

endmodule

### hw/rtl/stlb_ctrl.sv
// stlb_ctrl: sequencer for table writes and bisection steps, owns output valid.
// Depends on stlb_pkg.
module stlb_ctrl
    import stlb_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    input  stlb_status_t status,
    output stlb_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEEK,   // read issued at probe (or final) address
        ST_CMP,    // probe data back, narrow bounds
        ST_FIN     // final entry back, wait for free output slot
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (req_t'(s_tuser) == REQ_WRITE) begin
                        cmd.wr_en = 1'b1;
                    end else begin
                        cmd.load   = 1'b1;
                        state_next = ST_SEEK;
                    end
                end
            end
            ST_SEEK: begin
                state_next = status.more ? ST_CMP : ST_FIN;
            end
            ST_CMP: begin
                cmd.step   = 1'b1;
                state_next = ST_SEEK;
            end
            ST_FIN: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

endmodule

### hw/rtl/sorted_table_lower_bound_search_core.sv
// sorted_table_lower_bound_search_core: top level of the lower-bound search block.
// Depends on stlb_pkg, stlb_ctrl and stlb_dp.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-------------------------------------------
//  s_      | in  | s_tvalid/s_tready  | s_tuser=req_type, s_tdata (160 bits)
//  m_      | out | m_tvalid/m_tready  | m_tuser=found, m_tdata=position (16 bits)
//  cfg_    | in  | cfg_wen            | cfg_wdata=signed_compare
//
// A write word leaves the input open for the next word. A search word runs N bisection
// steps (ceil(log2(L+1)) for the range length L after the cut at the table end, at
// most 11), then a final table read: each step is a registered table read followed
// by a compare, on the single read port.
// Reset (aresetn low, sync) clears the sequencer, output valid and signed_compare;
// the table is not cleared. A stalled result sits in the output register while
// the next word is accepted; a finished search waits only if that register is full.
module sorted_table_lower_bound_search_core
    import stlb_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration
    input  logic                  cfg_wen,
    input  logic                  cfg_wdata,   // signed_compare
    // request stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic                  s_tuser,     // req_type
    // tdata, low to high: entry_index[9:0], entry_value[73:10], search_key[137:74],
    // range_start[147:138], range_len[158:148], zero pad[159]
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic                  m_tuser,     // found
    // tdata, low to high: position[10:0], zero pad[15:11]
    output logic [M_TDATA_W-1:0]  m_tdata
);

    stlb_cmd_t             cmd;
    stlb_status_t          status;
    logic [POSITION_W-1:0] position;

    // sequencer: one word at a time, bisection steps paced by table reads
    stlb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // table, bounds, key compare and result register
    stlb_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wen      (cfg_wen),
        .cfg_wdata    (cfg_wdata),
        .s_tdata      (s_tdata),
        .cmd          (cmd),
        .status       (status),
        .found_out    (m_tuser),
        .position_out (position)
    );

    assign m_tdata = M_TDATA_W'(position);

`ifndef SYNTHESIS
    // result only moves into the output register when that register is free
    a_out_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_tvalid || m_tready))
        else $error("result loaded over an untaken result");

    // an accepted search keeps the input closed on the next cycle
    a_search_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (req_t'(s_tuser) == REQ_SEARCH)) |=> !s_tready)
        else $error("input reopened right after a search word");

    // a write completes in its own cycle
    a_write_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (req_t'(s_tuser) == REQ_WRITE)) |=> s_tready)
        else $error("write word stalled the input");

    // positions never pass the table end
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (position <= POSITION_W'(DEPTH)))
        else $error("position beyond table end");
`endif

endmodule
